/* rtl/core/obfat_pkg.sv */
// shared constants and types for the look-at basis block
package obfat_pkg;

  // width of a magnitude after normalizing its leading one into bit 30
  localparam int MAG_W = 31;
  // width of the sum of squares fed to the square root
  localparam int SUM_W = 64;
  // width of the square root result
  localparam int LEN_W = 32;
  // one step per result bit of the square root
  localparam int SQRT_STEPS = 32;

  // queue status seen by the front end
  typedef struct packed {
    logic full;
    logic afull;
    logic empty;
  } fifo_stat_t;

endpackage

/* rtl/core/obfat_queue.sv */
// short request queue between front end and back end
module obfat_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [W-1:0]           push_data,
  input  logic                   pop,
  output logic [W-1:0]           pop_data,
  output obfat_pkg::fifo_stat_t  stat
);
  import obfat_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] cnt;
  logic          do_push;
  logic          do_pop;

  assign do_push = push && (cnt != CW'(DEPTH));
  assign do_pop  = pop && (cnt != '0);

  // status, almost full leaves room for the two front stages in flight
  assign stat.full  = (cnt == CW'(DEPTH));
  assign stat.afull = (cnt >= CW'(DEPTH - 2));
  assign stat.empty = (cnt == '0);

  assign pop_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      cnt <= cnt + CW'(do_push) - CW'(do_pop);
    end
  end

  // a request is never pushed into a full queue
  assert property (@(posedge clk) disable iff (rst) !(push && stat.full))
    else $error("request pushed into full queue");

endmodule

/* rtl/core/obfat_front.sv */
// front end: request capture and the right cross product
module obfat_front #(
  parameter int CB = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [CB-1:0]        at_x,
  input  logic signed [CB-1:0]        at_y,
  input  logic signed [CB-1:0]        at_z,
  input  logic signed [CB-1:0]        up_x,
  input  logic signed [CB-1:0]        up_y,
  input  logic signed [CB-1:0]        up_z,
  input  obfat_pkg::fifo_stat_t       stat,
  output logic                        push,
  output logic [2:0][2*CB-1:0]        cr,
  output logic [2:0][CB-1:0]          up_o
);
  import obfat_pkg::*;

  localparam int W = 2 * CB;

  logic                 s0_valid;
  logic signed [CB-1:0] s0_at [3];
  logic signed [CB-1:0] s0_up [3];
  logic signed [W-1:0]  ax [3];
  logic signed [W-1:0]  ux [3];
  logic signed [W-1:0]  c0;
  logic signed [W-1:0]  c1;
  logic signed [W-1:0]  c2;

  assign busy = stat.afull;

  // capture stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_at[0] <= at_x;
    s0_at[1] <= at_y;
    s0_at[2] <= at_z;
    s0_up[0] <= up_x;
    s0_up[1] <= up_y;
    s0_up[2] <= up_z;
  end

  // right = cross(up, at), exact in twice the component width
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ax[i] = W'(s0_at[i]);
      ux[i] = W'(s0_up[i]);
    end
    c0 = ux[1] * ax[2] - ux[2] * ax[1];
    c1 = ux[2] * ax[0] - ux[0] * ax[2];
    c2 = ux[0] * ax[1] - ux[1] * ax[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      push <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    cr[0] <= c0;
    cr[1] <= c1;
    cr[2] <= c2;
    for (int i = 0; i < 3; i++) begin
      up_o[i] <= s0_up[i];
    end
  end

endmodule

/* rtl/core/obfat_norm.sv */
// pipelined vector normalizer: leading-one shift, square root, rounded divide
module obfat_norm #(
  parameter int CB     = 16,
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [2:0][2*CB-1:0]  in_vec,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  output logic [2:0][CB-1:0]    out_vec,
  output logic                  out_deg,
  output logic [SIDE_W-1:0]     out_side
);
  import obfat_pkg::*;

  localparam int W     = 2 * CB;
  localparam int FRAC  = CB - 2;
  localparam int QB    = CB;
  localparam int NW    = CB + MAG_W;
  localparam int BL_W  = $clog2(W + 1);
  localparam int RW    = LEN_W + 1;
  localparam int SQ_W  = 2 * MAG_W;
  localparam int NEG_LO  = 3 * MAG_W;
  localparam int DEG_B   = NEG_LO + 3;
  localparam int SIDE_LO = DEG_B + 1;
  localparam int IW      = SIDE_LO + SIDE_W;
  localparam logic [CB-1:0] COMP_MAX = {1'b0, {(CB - 1){1'b1}}};
  localparam logic [CB-1:0] COMP_MIN = {1'b1, {(CB - 1){1'b0}}};

  // magnitude stage
  logic                s1_valid;
  logic [W-1:0]        s1_mag [3];
  logic [2:0]          s1_neg;
  logic [SIDE_W-1:0]   s1_side;

  // bit length stage
  logic                s2_valid;
  logic [W-1:0]        s2_mag [3];
  logic [2:0]          s2_neg;
  logic                s2_deg;
  logic [BL_W-1:0]     s2_bl;
  logic [SIDE_W-1:0]   s2_side;
  logic [W-1:0]        orv;
  logic [BL_W-1:0]     bl;

  // shift stage
  logic                s3_valid;
  logic [IW-1:0]       s3_info;
  logic [MAG_W-1:0]    sh_m [3];

  // square stage
  logic                s4_valid;
  logic [IW-1:0]       s4_info;
  logic [SQ_W-1:0]     s4_sq [3];

  // square root chain
  logic [SUM_W-1:0]    sq_x    [SQRT_STEPS+1];
  logic [SUM_W-1:0]    sq_r    [SQRT_STEPS+1];
  logic [IW-1:0]       sq_info [SQRT_STEPS+1];
  logic                sq_v    [SQRT_STEPS+1];

  // divide chain
  logic [2:0][RW-1:0]  dv_rem  [QB+1];
  logic [2:0][QB-1:0]  dv_low  [QB+1];
  logic [2:0][QB-1:0]  dv_q    [QB+1];
  logic [RW-1:0]       dv_d    [QB+1];
  logic [IW-1:0]       dv_info [QB+1];
  logic                dv_v    [QB+1];

  logic [LEN_W-1:0]    len;
  logic [NW-1:0]       num [3];

  // signs and magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s1_neg[i] <= in_vec[i][W-1];
      s1_mag[i] <= in_vec[i][W-1] ? W'(-in_vec[i]) : in_vec[i];
    end
    s1_side <= in_side;
  end

  // bit length of the largest magnitude
  always_comb begin
    orv = s1_mag[0] | s1_mag[1] | s1_mag[2];
    bl  = '0;
    for (int b = 0; b < W; b++) begin
      if (orv[b]) begin
        bl = BL_W'(b + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_mag  <= s1_mag;
    s2_neg  <= s1_neg;
    s2_deg  <= (orv == '0);
    s2_bl   <= bl;
    s2_side <= s1_side;
  end

  // move the leading one into bit 30, truncating below
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh_m[i] = MAG_W'({s2_mag[i], {MAG_W{1'b0}}} >> s2_bl);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_info <= {s2_side, s2_deg, s2_neg, sh_m[2], sh_m[1], sh_m[0]};
  end

  // squares
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s4_sq[i] <= s3_info[i*MAG_W +: MAG_W] * s3_info[i*MAG_W +: MAG_W];
    end
    s4_info <= s3_info;
  end

  // sum of squares enters the root chain
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v[0] <= 1'b0;
    end else begin
      sq_v[0] <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    sq_x[0]    <= SUM_W'(s4_sq[0]) + SUM_W'(s4_sq[1]) + SUM_W'(s4_sq[2]);
    sq_r[0]    <= '0;
    sq_info[0] <= s4_info;
  end

  // one square root step per stage, two radicand bits and one result bit each
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * k);
    logic [SUM_W-1:0] trial;
    logic [SUM_W-1:0] x_next;
    logic [SUM_W-1:0] r_next;

    always_comb begin
      trial = sq_r[k] + BIT;
      if (sq_x[k] >= trial) begin
        x_next = sq_x[k] - trial;
        r_next = (sq_r[k] >> 1) + BIT;
      end else begin
        x_next = sq_x[k];
        r_next = sq_r[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else begin
        sq_v[k+1] <= sq_v[k];
      end
    end

    always_ff @(posedge clk) begin
      sq_x[k+1]    <= x_next;
      sq_r[k+1]    <= r_next;
      sq_info[k+1] <= sq_info[k];
    end
  end

  // dividend m * 2^(FRAC+1) + len, divisor 2 * len
  assign len = sq_r[SQRT_STEPS][LEN_W-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = (NW'(sq_info[SQRT_STEPS][i*MAG_W +: MAG_W]) << (FRAC + 1)) + NW'(len);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else begin
      dv_v[0] <= sq_v[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dv_rem[0][i] <= RW'(num[i][NW-1:QB]);
      dv_low[0][i] <= num[i][QB-1:0];
      dv_q[0][i]   <= '0;
    end
    dv_d[0]    <= {len, 1'b0};
    dv_info[0] <= sq_info[SQRT_STEPS];
  end

  // restoring divide, one quotient bit per stage for each lane
  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [2:0][RW-1:0] rem_next;
    logic [2:0][QB-1:0] q_next;
    logic [RW:0]        t [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i] = {dv_rem[j][i], dv_low[j][i][QB-1]};
        if (t[i] >= {1'b0, dv_d[j]}) begin
          rem_next[i] = RW'(t[i] - {1'b0, dv_d[j]});
          q_next[i]   = {dv_q[j][i][QB-2:0], 1'b1};
        end else begin
          rem_next[i] = t[i][RW-1:0];
          q_next[i]   = {dv_q[j][i][QB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j+1] <= 1'b0;
      end else begin
        dv_v[j+1] <= dv_v[j];
      end
    end

    always_ff @(posedge clk) begin
      for (int i = 0; i < 3; i++) begin
        dv_low[j+1][i] <= {dv_low[j][i][QB-2:0], 1'b0};
      end
      dv_rem[j+1]  <= rem_next;
      dv_q[j+1]    <= q_next;
      dv_d[j+1]    <= dv_d[j];
      dv_info[j+1] <= dv_info[j];
    end
  end

  // saturate, restore sign, zero a degenerate vector
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv_v[QB];
    end
  end

  always_ff @(posedge clk) begin
    logic [CB-1:0] sat;
    for (int i = 0; i < 3; i++) begin
      sat = dv_q[QB][i][QB-1] ? COMP_MAX : dv_q[QB][i];
      if (dv_info[QB][DEG_B]) begin
        out_vec[i] <= '0;
      end else if (dv_info[QB][NEG_LO + i]) begin
        out_vec[i] <= CB'(-sat);
      end else begin
        out_vec[i] <= sat;
      end
    end
    out_deg  <= dv_info[QB][DEG_B];
    out_side <= dv_info[QB][SIDE_LO +: SIDE_W];
  end

  // clamping before the sign flip keeps the most negative code out of reach
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_vec[0] != COMP_MIN) && (out_vec[1] != COMP_MIN)
                  && (out_vec[2] != COMP_MIN))
    else $error("normalized component reached the most negative code");

  // a degenerate vector leaves as zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_deg |-> (out_vec[0] == '0) && (out_vec[1] == '0)
                             && (out_vec[2] == '0))
    else $error("degenerate vector not zero");

endmodule

/* rtl/core/obfat_back.sv */
// back end: normalize right, forward cross product, normalize forward
module obfat_back #(
  parameter int CB = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [2:0][2*CB-1:0]  cr,
  input  logic [2:0][CB-1:0]    up,
  output logic                  out_valid,
  output logic [2:0][CB-1:0]    rt,
  output logic                  rdeg,
  output logic [2:0][CB-1:0]    fw,
  output logic                  fdeg
);
  import obfat_pkg::*;

  localparam int W   = 2 * CB;
  localparam int S1W = 3 * CB;
  localparam int S2W = 3 * CB + 1;

  logic                 n1_valid;
  logic [2:0][CB-1:0]   n1_vec;
  logic                 n1_deg;
  logic [S1W-1:0]       n1_side;

  logic                 cf_valid;
  logic [2:0][W-1:0]    cf;
  logic [S2W-1:0]       cf_side;
  logic signed [W-1:0]  rx [3];
  logic signed [W-1:0]  ux [3];
  logic signed [W-1:0]  f0;
  logic signed [W-1:0]  f1;
  logic signed [W-1:0]  f2;

  logic [S2W-1:0]       n2_side;

  // normalize right, the up vector rides along
  obfat_norm #(.CB(CB), .SIDE_W(S1W)) u_norm_right (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_vec    (cr),
    .in_side   (up),
    .out_valid (n1_valid),
    .out_vec   (n1_vec),
    .out_deg   (n1_deg),
    .out_side  (n1_side)
  );

  // forward = cross(right, up)
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rx[i] = W'($signed(n1_vec[i]));
      ux[i] = W'($signed(n1_side[i*CB +: CB]));
    end
    f0 = rx[1] * ux[2] - rx[2] * ux[1];
    f1 = rx[2] * ux[0] - rx[0] * ux[2];
    f2 = rx[0] * ux[1] - rx[1] * ux[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cf_valid <= 1'b0;
    end else begin
      cf_valid <= n1_valid;
    end
  end

  always_ff @(posedge clk) begin
    cf[0]   <= f0;
    cf[1]   <= f1;
    cf[2]   <= f2;
    cf_side <= {n1_deg, n1_vec};
  end

  // normalize forward, right and its flag ride along
  obfat_norm #(.CB(CB), .SIDE_W(S2W)) u_norm_fwd (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cf_valid),
    .in_vec    (cf),
    .in_side   (cf_side),
    .out_valid (out_valid),
    .out_vec   (fw),
    .out_deg   (fdeg),
    .out_side  (n2_side)
  );

  assign rt   = n2_side[S1W-1:0];
  assign rdeg = n2_side[S1W];

endmodule

/* rtl/core/orthonormal_basis_from_at_up.sv */
// top level: look-at basis (normalized right and forward) from at and up
//
//   channel   | handshake     | fields
//   ----------+---------------+-------------------------------------------------
//   request   | start / busy  | at_x at_y at_z up_x up_y up_z
//   result    | done (strobe) | right_x..z fwd_x..z right_degenerate fwd_degenerate
//
// one request per cycle while busy is low; busy rises only if the queue
// between front and back end nears full, which the back end never lets happen
// the path from request to done runs through the two 32-step square root chains
// and the COMP_BITS-step dividers in each normalizer
// synchronous reset empties the queue and clears every valid bit
// results leave on done for one cycle; the receiver cannot stall them
module orthonormal_basis_from_at_up #(
  parameter int COMP_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [COMP_BITS-1:0] at_x,
  input  logic signed [COMP_BITS-1:0] at_y,
  input  logic signed [COMP_BITS-1:0] at_z,
  input  logic signed [COMP_BITS-1:0] up_x,
  input  logic signed [COMP_BITS-1:0] up_y,
  input  logic signed [COMP_BITS-1:0] up_z,
  output logic                        done,
  output logic signed [COMP_BITS-1:0] right_x,
  output logic signed [COMP_BITS-1:0] right_y,
  output logic signed [COMP_BITS-1:0] right_z,
  output logic signed [COMP_BITS-1:0] fwd_x,
  output logic signed [COMP_BITS-1:0] fwd_y,
  output logic signed [COMP_BITS-1:0] fwd_z,
  output logic                        right_degenerate,
  output logic                        fwd_degenerate
);
  import obfat_pkg::*;

  localparam int CB  = COMP_BITS;
  localparam int W   = 2 * CB;
  localparam int QW  = 3 * W + 3 * CB;

  fifo_stat_t           stat;
  logic                 push;
  logic [2:0][W-1:0]    cr;
  logic [2:0][CB-1:0]   up_f;
  logic [QW-1:0]        q_out;
  logic [2:0][W-1:0]    q_cr;
  logic [2:0][CB-1:0]   q_up;
  logic [2:0][CB-1:0]   rt;
  logic [2:0][CB-1:0]   fw;

  // front end
  obfat_front #(.CB(CB)) u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .at_x  (at_x),
    .at_y  (at_y),
    .at_z  (at_z),
    .up_x  (up_x),
    .up_y  (up_y),
    .up_z  (up_z),
    .stat  (stat),
    .push  (push),
    .cr    (cr),
    .up_o  (up_f)
  );

  // decoupling queue, the back end drains one request per cycle
  obfat_queue #(.W(QW), .DEPTH(4)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({cr, up_f}),
    .pop       (!stat.empty),
    .pop_data  (q_out),
    .stat      (stat)
  );

  assign q_cr = q_out[QW-1:3*CB];
  assign q_up = q_out[3*CB-1:0];

  // back end
  obfat_back #(.CB(CB)) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (!stat.empty),
    .cr        (q_cr),
    .up        (q_up),
    .out_valid (done),
    .rt        (rt),
    .rdeg      (right_degenerate),
    .fw        (fw),
    .fdeg      (fwd_degenerate)
  );

  assign right_x = rt[0];
  assign right_y = rt[1];
  assign right_z = rt[2];
  assign fwd_x   = fw[0];
  assign fwd_y   = fw[1];
  assign fwd_z   = fw[2];

  // a zero right axis always gives a zero forward axis
  assert property (@(posedge clk) disable iff (rst)
    done && right_degenerate |-> fwd_degenerate)
    else $error("degenerate right with non-degenerate forward");

  // the back end keeps up, so the queue never reaches almost full
  assert property (@(posedge clk) disable iff (rst) !stat.afull)
    else $error("request queue backed up");

endmodule
